// ----- rtl/adll_pkg.sv -----
`timescale 1ns / 1ps

package adll_pkg;

    // Default sizes of the list store.
    localparam int CAPACITY_DEF   = 256;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the request and response transactions.
    localparam int MODE_W  = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int CELL_W  = 8;
    localparam int STAT_W  = 2;

    // Request modes.
    localparam logic [MODE_W-1:0] MODE_APPEND      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE_TAIL = 2'd2;
    localparam logic [MODE_W-1:0] MODE_REMOVE_POS  = 2'd3;

    // Response status codes.
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } req_t;

    typedef struct packed {
        logic [CELL_W-1:0]         cell_index;
        logic signed [VALUE_W-1:0] removed_value;
        logic [STAT_W-1:0]         status;
    } rsp_t;

endpackage

// ----- rtl/adll_ram.sv -----
`timescale 1ns / 1ps

module adll_ram
    import adll_pkg::*;
#(
    parameter int WIDTH = DATA_WIDTH_DEF,
    parameter int DEPTH = CAPACITY_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/array_doubly_linked_list_core.sv -----
`timescale 1ns / 1ps
// Sequence: an insert steps through S_DECIDE, S_INS_A, S_INS_B and S_DONE, a remove
// through S_DECIDE, S_REM_A, S_REM_B and S_DONE; a full store or an empty list goes
// from S_DECIDE to S_DONE. One request at a time: req_ready is high only in S_IDLE,
// which follows once the response is loaded; each memory takes one write per cycle.
// Reset: asynchronous, active low; the free list is formed lazily by a fill count,
// so requests are taken in the first cycle after reset.
module array_doubly_linked_list_core
    import adll_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECIDE = 7'b0000010,
        S_INS_A  = 7'b0000100,
        S_INS_B  = 7'b0001000,
        S_REM_A  = 7'b0010000,
        S_REM_B  = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    req_t   req_reg, req_next;
    rsp_t   res_reg, res_next;
    rsp_t   rsp_reg, rsp_next;
    logic   rsp_valid_reg, rsp_valid_next;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [IDX_W-1:0] free_reg, free_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] c_reg, c_next;
    logic [IDX_W-1:0] p_reg, p_next;
    logic [IDX_W-1:0] n_reg, n_next;

    // Memory ports: next links, previous links with the in-use flag on top, and values.
    logic                  nx_we, pv_we, vl_we;
    logic [IDX_W-1:0]      nx_waddr, pv_waddr, vl_waddr;
    logic [IDX_W-1:0]      nx_wdata, nx_rdata;
    logic [IDX_W:0]        pv_wdata, pv_rdata;
    logic [DATA_WIDTH-1:0] vl_wdata, vl_rdata;
    logic [IDX_W-1:0]      nx_raddr, pv_raddr, vl_raddr;

    logic [IDX_W-1:0] pos_idx;
    logic             pos_live;
    logic [IDX_W-1:0] c_sel;
    logic [CNT_W-1:0] fill_inc;
    logic             load_rsp;

    adll_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next_ram (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (nx_raddr),
        .rdata (nx_rdata)
    );

    adll_ram #(.WIDTH(IDX_W + 1), .DEPTH(CAPACITY)) u_prev_ram (
        .clk   (clk),
        .we    (pv_we),
        .waddr (pv_waddr),
        .wdata (pv_wdata),
        .raddr (pv_raddr),
        .rdata (pv_rdata)
    );

    adll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_value_ram (
        .clk   (clk),
        .we    (vl_we),
        .waddr (vl_waddr),
        .wdata (vl_wdata),
        .raddr (vl_raddr),
        .rdata (vl_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A position names a live cell when it is in range, has been handed out at
    // least once, and its in-use flag is set. Cells at or past the fill mark are unused.
    assign pos_idx  = IDX_W'(req_reg.position);
    assign pos_live = (req_reg.position != '0)
                   && (32'(req_reg.position) < CAPACITY)
                   && (CNT_W'(pos_idx) < fill_reg)
                   && pv_rdata[IDX_W];

    // Cell to release on a remove request.
    always_comb
    begin
        if (req_reg.mode == MODE_REMOVE_TAIL)
        begin
            c_sel = tail_reg;
        end
        else if (pos_live)
        begin
            c_sel = pos_idx;
        end
        else
        begin
            c_sel = '0;
        end
    end

    assign fill_inc = fill_reg + 1'b1;
    assign load_rsp = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    // Sequencer and memory access control.
    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        res_next   = res_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        free_next  = free_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        c_next     = c_reg;
        p_next     = p_reg;
        n_next     = n_reg;

        nx_we    = 1'b0;
        nx_waddr = '0;
        nx_wdata = '0;
        pv_we    = 1'b0;
        pv_waddr = '0;
        pv_wdata = '0;
        vl_we    = 1'b0;
        vl_waddr = c_reg;
        vl_wdata = DATA_WIDTH'($unsigned(req_reg.value));
        nx_raddr = '0;
        pv_raddr = '0;
        vl_raddr = '0;

        case (state_reg)
            S_IDLE:
            begin
                // Look up the request position while it is being taken.
                nx_raddr = IDX_W'(req.position);
                pv_raddr = IDX_W'(req.position);
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if ((req_reg.mode == MODE_APPEND) || (req_reg.mode == MODE_INSERT))
                begin
                    if (free_reg == '0)
                    begin
                        res_next.cell_index    = '0;
                        res_next.removed_value = '0;
                        res_next.status        = STATUS_FULL;
                        state_next             = S_DONE;
                    end
                    else
                    begin
                        c_next = free_reg;
                        if ((req_reg.mode == MODE_INSERT) && (req_reg.position == '0)
                            && (tail_reg != '0))
                        begin
                            p_next = '0;
                            n_next = head_reg;
                        end
                        else if ((req_reg.mode == MODE_INSERT) && pos_live
                                 && (pos_idx != tail_reg))
                        begin
                            p_next = pos_idx;
                            n_next = nx_rdata;
                        end
                        else
                        begin
                            p_next = tail_reg;
                            n_next = '0;
                        end
                        // Fetch the link that follows the free cell.
                        nx_raddr   = free_reg;
                        state_next = S_INS_A;
                    end
                end
                else
                begin
                    if ((count_reg == '0) || (c_sel == '0))
                    begin
                        res_next.cell_index    = '0;
                        res_next.removed_value = '0;
                        res_next.status        = STATUS_EMPTY;
                        state_next             = S_DONE;
                    end
                    else
                    begin
                        c_next     = c_sel;
                        nx_raddr   = c_sel;
                        pv_raddr   = c_sel;
                        vl_raddr   = c_sel;
                        state_next = S_REM_A;
                    end
                end
            end

            S_INS_A:
            begin
                // Pop the free list; a cell at the fill mark chains to the next one.
                if (CNT_W'(c_reg) == fill_reg)
                begin
                    fill_next = fill_inc;
                    if (32'(fill_inc) == CAPACITY)
                    begin
                        free_next = '0;
                    end
                    else
                    begin
                        free_next = IDX_W'(fill_inc);
                    end
                end
                else
                begin
                    free_next = nx_rdata;
                end
                vl_we      = 1'b1;
                nx_we      = 1'b1;
                nx_waddr   = c_reg;
                nx_wdata   = n_reg;
                pv_we      = 1'b1;
                pv_waddr   = c_reg;
                pv_wdata   = {1'b1, p_reg};
                count_next = count_reg + 1'b1;
                state_next = S_INS_B;
            end

            S_INS_B:
            begin
                // Hook the new cell into its neighbors; the sentinel lives in registers.
                if (p_reg == '0)
                begin
                    head_next = c_reg;
                end
                else
                begin
                    nx_we    = 1'b1;
                    nx_waddr = p_reg;
                    nx_wdata = c_reg;
                end
                if (n_reg == '0)
                begin
                    tail_next = c_reg;
                end
                else
                begin
                    pv_we    = 1'b1;
                    pv_waddr = n_reg;
                    pv_wdata = {1'b1, c_reg};
                end
                res_next.cell_index    = CELL_W'(c_reg);
                res_next.removed_value = '0;
                res_next.status        = STATUS_OK;
                state_next             = S_DONE;
            end

            S_REM_A:
            begin
                // Bridge the neighbors of the cell being removed.
                if (pv_rdata[IDX_W-1:0] == '0)
                begin
                    head_next = nx_rdata;
                end
                else
                begin
                    nx_we    = 1'b1;
                    nx_waddr = pv_rdata[IDX_W-1:0];
                    nx_wdata = nx_rdata;
                end
                if (nx_rdata == '0)
                begin
                    tail_next = pv_rdata[IDX_W-1:0];
                end
                else
                begin
                    pv_we    = 1'b1;
                    pv_waddr = nx_rdata;
                    pv_wdata = {1'b1, pv_rdata[IDX_W-1:0]};
                end
                res_next.removed_value = VALUE_W'(vl_rdata);
                state_next             = S_REM_B;
            end

            S_REM_B:
            begin
                // Push the freed cell on the front of the free list.
                nx_we                  = 1'b1;
                nx_waddr               = c_reg;
                nx_wdata               = free_reg;
                pv_we                  = 1'b1;
                pv_waddr               = c_reg;
                pv_wdata               = '0;
                free_next              = c_reg;
                count_next             = count_reg - 1'b1;
                res_next.cell_index    = CELL_W'(c_reg);
                res_next.status        = STATUS_OK;
                state_next             = S_DONE;
            end

            S_DONE:
            begin
                if (load_rsp)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register holds a response until the transaction completes.
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (load_rsp)
        begin
            rsp_next       = res_reg;
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            free_reg      <= IDX_W'(1);
            fill_reg      <= CNT_W'(1);
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            free_reg      <= free_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
        c_reg   <= c_next;
        p_reg   <= p_next;
        n_reg   <= n_next;
    end

endmodule

// ----- rtl/adll_checker.sv -----
`timescale 1ns / 1ps

module adll_checker
    import adll_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // A stalled response transaction keeps its payload.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response changed while stalled");

    // The block works on one request at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // A flagged request reports no cell and no value.
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != STATUS_OK)
        |-> (rsp.cell_index == '0) && (rsp.removed_value == '0))
        else $error("flagged response carries data");

    // Only defined status codes appear.
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == STATUS_OK) || (rsp.status == STATUS_FULL)
                   || (rsp.status == STATUS_EMPTY))
        else $error("undefined status code");

endmodule

bind array_doubly_linked_list_core adll_checker u_adll_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import adll_pkg::*;

    localparam int CELLS        = CAPACITY_DEF;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    // One row of the directed table: the request, and optionally its answer.
    typedef struct {
        req_t stim;
        bit   typed;
        rsp_t answer;
    } list_case_t;

    list_case_t list_cases[$];
    rsp_t       pending_rsp[$];

    // Shadow copy of the list store.
    logic [VALUE_W-1:0] list_data[CELLS];
    logic [CELL_W-1:0]  list_next[CELLS];
    logic [CELL_W-1:0]  list_prev[CELLS];
    bit                 list_live[CELLS];
    logic [CELL_W-1:0]  list_head;
    logic [CELL_W-1:0]  list_tail;
    logic [CELL_W-1:0]  list_free;
    int                 list_count;

    int error_count = 0;
    int idle_cycles = 0;
    bit req_steady  = 1'b0;
    bit rsp_steady  = 1'b0;

    always #10 clk = ~clk;

    array_doubly_linked_list_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(string msg);
        error_count++;
        $display("tb_top: mismatch at %0t: %s", $realtime, msg);
    endtask

    // Applies one request to the shadow list and returns the answer it should get.
    function automatic rsp_t apply_list_op(req_t r);
        rsp_t              res;
        logic [CELL_W-1:0] c;
        logic [CELL_W-1:0] p;
        logic [CELL_W-1:0] n;
        res = '0;
        if (r.mode == MODE_APPEND || r.mode == MODE_INSERT)
        begin
            if (list_free == 0)
            begin
                res.status = STATUS_FULL;
            end
            else
            begin
                // Pick the neighbors: head insert, insert after a live non-tail
                // cell, or fall back to an append at the tail.
                if (r.mode == MODE_INSERT && r.position == 0 && list_tail != 0)
                begin
                    p = 0;
                    n = list_head;
                end
                else if (r.mode == MODE_INSERT && r.position != 0 && list_live[r.position]
                         && r.position != list_tail)
                begin
                    p = r.position;
                    n = list_next[r.position];
                end
                else
                begin
                    p = list_tail;
                    n = 0;
                end
                c = list_free;
                list_free = list_next[c];
                list_data[c] = r.value;
                list_live[c] = 1'b1;
                list_count++;
                list_next[c] = n;
                list_prev[c] = p;
                list_next[p] = c;
                list_prev[n] = c;
                list_head = list_next[0];
                list_tail = list_prev[0];
                res.cell_index = c;
            end
        end
        else
        begin
            if (r.mode == MODE_REMOVE_TAIL)
                c = list_tail;
            else if (r.position != 0 && list_live[r.position])
                c = r.position;
            else
                c = 0;
            if (list_count == 0 || c == 0)
            begin
                res.status = STATUS_EMPTY;
            end
            else
            begin
                // Unlink the cell and push it on the front of the free chain.
                p = list_prev[c];
                n = list_next[c];
                list_next[p] = n;
                list_prev[n] = p;
                list_head = list_next[0];
                list_tail = list_prev[0];
                list_next[c] = list_free;
                list_prev[c] = 0;
                list_live[c] = 1'b0;
                list_free = c;
                list_count--;
                res.cell_index = c;
                res.removed_value = list_data[c];
            end
        end
        return res;
    endfunction

    function automatic void add_case(logic [MODE_W-1:0] m, logic [VALUE_W-1:0] v,
                                     logic [POS_W-1:0] pos, bit typed = 1'b0,
                                     logic [CELL_W-1:0] c = 0, logic [VALUE_W-1:0] rv = 0,
                                     logic [STAT_W-1:0] st = STATUS_OK);
        list_case_t row;
        row.stim.mode = m;
        row.stim.value = v;
        row.stim.position = pos;
        row.typed = typed;
        row.answer.cell_index = c;
        row.answer.removed_value = rv;
        row.answer.status = st;
        list_cases.push_back(row);
    endfunction

    // Chooses a position: mostly live cells, sometimes the tail, the sentinel,
    // any index, or the next free cell.
    function automatic logic [POS_W-1:0] pick_position();
        int                r;
        int                k;
        logic [CELL_W-1:0] c;
        r = $urandom_range(0, 99);
        if (r < 60 && list_count > 0)
        begin
            k = $urandom_range(0, list_count - 1);
            c = list_head;
            repeat (k) c = list_next[c];
            return c;
        end
        if (r < 70)
            return list_tail;
        if (r < 78)
            return '0;
        if (r < 90)
            return POS_W'($urandom_range(0, 255));
        return list_free;
    endfunction

    function automatic req_t random_request(int insert_pct);
        req_t r;
        bit   grow;
        grow = ($urandom_range(0, 99) < insert_pct);
        if (grow)
            r.mode = $urandom_range(0, 1) ? MODE_INSERT : MODE_APPEND;
        else
            r.mode = $urandom_range(0, 1) ? MODE_REMOVE_POS : MODE_REMOVE_TAIL;
        case ($urandom_range(0, 9))
            0:       r.value = 32'h7fff_ffff;
            1:       r.value = 32'h8000_0000;
            2:       r.value = 32'h0000_0000;
            3:       r.value = 32'hffff_ffff;
            default: r.value = $urandom;
        endcase
        r.position = pick_position();
        return r;
    endfunction

    // Sends one request transaction and records what it should answer.
    task automatic send_request(req_t r, bit typed, rsp_t answer);
        int   gap;
        rsp_t predicted;
        if ($urandom_range(0, 19) == 0)
            req_steady = !req_steady;
        gap = req_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do @(posedge clk); while (req_ready !== 1'b1);
        predicted = apply_list_op(r);
        pending_rsp.push_back(typed ? answer : predicted);
    endtask

    // Compares one response transaction with the oldest expectation.
    task automatic check_rsp(rsp_t got);
        rsp_t want;
        if (pending_rsp.size() == 0)
        begin
            report_mismatch($sformatf("unexpected response %p", got));
        end
        else
        begin
            want = pending_rsp.pop_front();
            if (got.cell_index !== want.cell_index)
                report_mismatch($sformatf("cell_index %0d, want %0d",
                                          got.cell_index, want.cell_index));
            if (got.removed_value !== want.removed_value)
                report_mismatch($sformatf("removed_value %h, want %h",
                                          got.removed_value, want.removed_value));
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
        end
    endtask

    // Response side: random stalls, then take the next transaction.
    initial
    begin
        int stall;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                rsp_steady = !rsp_steady;
            stall = rsp_steady ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (rsp_valid !== 1'b1);
            check_rsp(rsp);
        end
    end

    // Watchdog: ends the run after too many cycles without any transaction.
    always @(posedge clk)
    begin
        if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then random phases.
    initial
    begin
        // Shadow list after reset: free chain 1 -> 2 -> ... -> 255 -> 0.
        for (int i = 0; i < CELLS; i++)
        begin
            list_data[i] = '0;
            list_prev[i] = '0;
            list_live[i] = 1'b0;
            list_next[i] = (i == 0 || i == CELLS - 1) ? '0 : CELL_W'(i + 1);
        end
        list_head = '0;
        list_tail = '0;
        list_free = CELL_W'(1);
        list_count = 0;

        // Empty-list removes, head and tail inserts, inserts after unused
        // cells, removes of free cells, and emptying the list completely.
        add_case(MODE_REMOVE_TAIL, 32'h0, 8'd0, 1, 0, 0, STATUS_EMPTY);
        add_case(MODE_REMOVE_POS, 32'h0, 8'd0, 1, 0, 0, STATUS_EMPTY);
        add_case(MODE_REMOVE_POS, 32'h0, 8'd255, 1, 0, 0, STATUS_EMPTY);
        add_case(MODE_INSERT, 32'h7fff_ffff, 8'd0, 1, 1, 0, STATUS_OK);
        add_case(MODE_INSERT, 32'h8000_0000, 8'd0, 1, 2, 0, STATUS_OK);
        add_case(MODE_INSERT, 32'h0000_0000, 8'd1, 1, 3, 0, STATUS_OK);
        add_case(MODE_APPEND, 32'hffff_ffff, 8'd255, 1, 4, 0, STATUS_OK);
        add_case(MODE_INSERT, 32'h5555_5555, 8'd200, 1, 5, 0, STATUS_OK);
        add_case(MODE_INSERT, 32'haaaa_aaaa, 8'd2);
        add_case(MODE_REMOVE_POS, 32'h0, 8'd200, 1, 0, 0, STATUS_EMPTY);
        add_case(MODE_REMOVE_POS, 32'h0, 8'd2, 1, 2, 32'h8000_0000, STATUS_OK);
        add_case(MODE_REMOVE_TAIL, 32'h0, 8'd0, 1, 5, 32'h5555_5555, STATUS_OK);
        add_case(MODE_REMOVE_POS, 32'h1234_5678, 8'd3);
        add_case(MODE_APPEND, 32'd123, 8'd0);
        add_case(MODE_REMOVE_POS, 32'h0, 8'd2, 1, 0, 0, STATUS_EMPTY);
        add_case(MODE_INSERT, 32'hdead_beef, 8'd4);
        repeat (5) add_case(MODE_REMOVE_TAIL, 32'hffff_ffff, 8'd255);
        add_case(MODE_REMOVE_TAIL, 32'h0, 8'd0, 1, 0, 0, STATUS_EMPTY);
        add_case(MODE_INSERT, 32'd7, 8'd0);
        add_case(MODE_REMOVE_POS, 32'h0, 8'd6);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (list_cases[i])
            send_request(list_cases[i].stim, list_cases[i].typed, list_cases[i].answer);

        // Mixed traffic, fill the store past full, drain it past empty, then mixed again.
        repeat (10) send_request(random_request(55), 1'b0, '0);
        while (list_free != 0)
            send_request(random_request(100), 1'b0, '0);
        repeat (3) send_request(random_request(100), 1'b0, '0);
        while (list_count != 0)
            send_request(random_request(0), 1'b0, '0);
        repeat (3) send_request(random_request(0), 1'b0, '0);
        repeat (10) send_request(random_request(55), 1'b0, '0);
        req_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
